[hw/rtl/xee_pkg.sv]
// Package for the XML entity escaper: types, entity text and the symbol function.
package xee_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned IdxW  = 3;   // up to eight symbols in one run

  localparam logic NarrowModeReset = 1'b1;

  localparam logic [CodeW-1:0] CtrlLimit  = 16'h0020;
  localparam logic [CodeW-1:0] AsciiLimit = 16'h0080;
  localparam logic [CodeW-1:0] CodeNbsp   = 16'h00A0;
  localparam logic [CodeW-1:0] Hex4Limit  = 16'h1000;
  localparam logic [CodeW-1:0] Hex3Limit  = 16'h0100;
  localparam logic [CodeW-1:0] Hex2Limit  = 16'h0010;

  typedef enum logic [2:0] {
    ENT_NONE,
    ENT_AMP,
    ENT_LT,
    ENT_GT,
    ENT_QUOT,
    ENT_APOS,
    ENT_NBSP
  } ent_e;

  typedef struct packed {
    logic [CodeW-1:0] symbol;
    logic             last;
  } esc_t;

  // Map a code to its named entity under the selected rules.
  function automatic ent_e ent_kind(logic [CodeW-1:0] code, logic narrow);
    ent_e kind;
    case (code)
      16'h0026: kind = ENT_AMP;
      16'h003C: kind = ENT_LT;
      16'h003E: kind = ENT_GT;
      16'h0022: kind = ENT_QUOT;
      16'h0027: kind = ENT_APOS;
      CodeNbsp: kind = narrow ? ENT_NONE : ENT_NBSP;
      default:  kind = ENT_NONE;
    endcase
    return kind;
  endfunction

  // Uppercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_char(logic [3:0] nv);
    logic [7:0] c;
    if (nv < 4'd10) begin
      c = 8'h30 + {4'h0, nv};
    end else begin
      c = 8'h37 + {4'h0, nv};
    end
    return c;
  endfunction

  // Symbol at position idx of the escaped run of one code, with its last flag.
  function automatic esc_t esc_symbol(logic [CodeW-1:0] code, logic narrow,
                                      logic [IdxW-1:0] idx);
    ent_e       kind;
    logic [2:0] ndig;
    logic [3:0] len;
    logic [47:0] txt;
    logic [2:0] pos;
    logic [1:0] k;
    logic [1:0] nib;
    logic [3:0] nv;
    esc_t       r;
    kind = ent_kind(code, narrow);
    ndig = 3'd1;
    len  = 4'd1;
    txt  = '0;
    pos  = '0;
    k    = '0;
    nib  = '0;
    nv   = '0;
    r.symbol = code;
    r.last   = 1'b1;
    if (narrow && (code < CtrlLimit || code >= AsciiLimit)) begin
      // numeric reference: &#x, digits without leading zeros, ;
      if (code >= Hex4Limit) begin
        ndig = 3'd4;
      end else if (code >= Hex3Limit) begin
        ndig = 3'd3;
      end else if (code >= Hex2Limit) begin
        ndig = 3'd2;
      end else begin
        ndig = 3'd1;
      end
      len = {1'b0, ndig} + 4'd4;
      k   = 2'(idx - 3'd3);
      nib = 2'(ndig - 3'd1) - k;
      nv  = code[{nib, 2'b00} +: 4];
      case (idx)
        3'd0:    r.symbol = {8'h00, 8'h26};
        3'd1:    r.symbol = {8'h00, 8'h23};
        3'd2:    r.symbol = {8'h00, 8'h78};
        default: begin
          if ({1'b0, idx} < 4'd3 + {1'b0, ndig}) begin
            r.symbol = {8'h00, hex_char(nv)};
          end else begin
            r.symbol = {8'h00, 8'h3B};
          end
        end
      endcase
      r.last = ({1'b0, idx} == len - 4'd1);
    end else if (kind != ENT_NONE) begin
      // named entity, text right-aligned in txt
      case (kind)
        ENT_AMP:  begin txt = 48'("&amp;");  len = 4'd5; end
        ENT_LT:   begin txt = 48'("&lt;");   len = 4'd4; end
        ENT_GT:   begin txt = 48'("&gt;");   len = 4'd4; end
        ENT_QUOT: begin txt = 48'("&quot;"); len = 4'd6; end
        ENT_APOS: begin txt = 48'("&apos;"); len = 4'd6; end
        ENT_NBSP: begin txt = 48'("&nbsp;"); len = 4'd6; end
        default:  begin txt = '0;            len = 4'd1; end
      endcase
      pos = 3'(len[2:0] - 3'd1 - idx);
      r.symbol = {8'h00, txt[{pos, 3'b000} +: 8]};
      r.last   = ({1'b0, idx} == len - 4'd1);
    end
    return r;
  endfunction

endpackage

[hw/rtl/xml_entity_escape_top.sv]
// XML entity escaper: one character code in, its escaped run of symbols out.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+------------------------
//   in      | sink      | in_valid_i / in_stall_o     | code_point_i
//   out     | source    | out_valid_o / out_stall_i   | symbol_o, last_o
//   cfg     | sink      | cfg_we_i                    | cfg_wdata_i (narrow_mode)
//
// Each code yields a run of 1 to 8 symbols, one symbol per cycle from the
// output register while the output is not stalled. The word is first captured
// into the input register, and its first symbol then moves on into the output
// register.
// The next word is accepted in the cycle the current run's last symbol moves
// into the output register. Reset empties both registers and sets narrow mode.
// A stall on the output holds the output register and, through it, the input.
module xml_entity_escape_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [xee_pkg::CodeW-1:0] code_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [xee_pkg::CodeW-1:0] symbol_o,
  output logic                      last_o
);
  import xee_pkg::*;

  logic             mode_q;
  logic             busy_q;
  logic [CodeW-1:0] code_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q;
  logic [CodeW-1:0] symbol_q;
  logic             last_q;

  logic             adv;
  logic             in_acc;
  esc_t             cur;

  // Compute the current symbol of the held word
  assign cur        = esc_symbol(code_q, mode_q, idx_q);
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q && !(adv && cur.last);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= NarrowModeReset;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Advance the input control: load a word, step through its run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && adv) begin
      if (cur.last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= code_point_i;
    end
  end

  // Advance the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= busy_q;
    end
  end

  // Capture the output word
  always_ff @(posedge clk_i) begin
    if (adv && busy_q) begin
      symbol_q <= cur.symbol;
      last_q   <= cur.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

  // A new word enters a busy stage only as its run's last symbol leaves
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && busy_q) |-> (adv && cur.last))
    else $error("input accepted while run still in progress");

  // A run that is not finished steps its index by one
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && adv && !cur.last && !in_acc) |=>
      (busy_q && idx_q == $past(idx_q) + IdxW'(1)))
    else $error("run index did not advance");

  // An idle stage holds index zero
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (idx_q == '0))
    else $error("index nonzero while idle");

  // A word that just entered starts at the first symbol
  a_start_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && idx_q == '0))
    else $error("new run did not start at index zero");

endmodule

[test/xml_entity_escape_top_test.sv]
// Self-checking testbench for the XML entity escaper: predicted symbol runs vs. the DUT output.
module xml_entity_escape_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xee_pkg::*;

  // Character codes that have a named entity
  localparam logic [CodeW-1:0] ChAmp  = 16'h0026;
  localparam logic [CodeW-1:0] ChLt   = 16'h003C;
  localparam logic [CodeW-1:0] ChGt   = 16'h003E;
  localparam logic [CodeW-1:0] ChQuot = 16'h0022;
  localparam logic [CodeW-1:0] ChApos = 16'h0027;

  localparam logic ModeWide   = 1'b0;
  localparam logic ModeNarrow = 1'b1;

  localparam int unsigned WordsPerPhase = 44;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic             cfg_wdata_i  = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [CodeW-1:0] code_point_i = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [CodeW-1:0] symbol_o;
  logic             last_o;

  // Predictor state and the run of symbols still owed by the DUT
  logic  narrow_mode = NarrowModeReset;
  esc_t  pending_symbols[$];
  int    mismatch_count = 0;
  int    send_idle_pct  = 0;
  int    stall_pct      = 0;

  xml_entity_escape_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_point_i (code_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_o     (symbol_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the output at random at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [CodeW-1:0] got,
                                 input logic [CodeW-1:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    string digits;
    digits = "0123456789ABCDEF";
    return digits[nibble];
  endfunction

  function automatic string entity_name(input logic [CodeW-1:0] cp, input logic wide);
    string txt;
    txt = "";
    case (cp)
      ChAmp:    txt = "&amp;";
      ChLt:     txt = "&lt;";
      ChGt:     txt = "&gt;";
      ChQuot:   txt = "&quot;";
      ChApos:   txt = "&apos;";
      CodeNbsp: txt = wide ? "&nbsp;" : "";
      default:  txt = "";
    endcase
    return txt;
  endfunction

  // Work out the escaped run of one code and queue it
  function automatic void predict_escape(input logic [CodeW-1:0] cp);
    logic [CodeW-1:0] run[$];
    string            txt;
    int               ndig;
    esc_t             word;
    if (narrow_mode && (cp < CtrlLimit || cp >= AsciiLimit)) begin
      ndig = (cp >= Hex4Limit) ? 4 : (cp >= Hex3Limit) ? 3 : (cp >= Hex2Limit) ? 2 : 1;
      txt = "&#x";
      for (int i = 0; i < txt.len(); i++) run.push_back(CodeW'(txt[i]));
      for (int d = ndig - 1; d >= 0; d--) run.push_back(CodeW'(hex_digit(cp[4*d +: 4])));
      run.push_back(CodeW'(8'h3B));
    end else begin
      txt = entity_name(cp, !narrow_mode);
      if (txt.len() == 0) begin
        run.push_back(cp);
      end else begin
        for (int i = 0; i < txt.len(); i++) run.push_back(CodeW'(txt[i]));
      end
    end
    for (int k = 0; k < run.size(); k++) begin
      word.symbol = run[k];
      word.last   = (k == run.size() - 1);
      pending_symbols.push_back(word);
    end
  endfunction

  // Compare each accepted output word with the oldest pending symbol
  always @(posedge clk_i) begin
    esc_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch("unexpected symbol", symbol_o, '0);
      end else begin
        want = pending_symbols.pop_front();
        if (symbol_o !== want.symbol) report_mismatch("symbol", symbol_o, want.symbol);
        if (last_o !== want.last) report_mismatch("last", CodeW'(last_o), CodeW'(want.last));
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_code(input logic [CodeW-1:0] cp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i   <= 1'b0;
      code_point_i <= CodeW'($urandom);
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_point_i <= cp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_escape(cp);
  endtask

  task automatic wait_drained();
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drop valid, let the DUT go idle, then write the mode register
  task automatic write_mode(input logic mode);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'($urandom);
    narrow_mode = mode;
  endtask

  function automatic logic [CodeW-1:0] pick_code();
    logic [CodeW-1:0] cp;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 5))
          0:       cp = ChAmp;
          1:       cp = ChLt;
          2:       cp = ChGt;
          3:       cp = ChQuot;
          4:       cp = ChApos;
          default: cp = CodeNbsp;
        endcase
      end
      2, 3:    cp = CodeW'($urandom_range(32'h20, 32'h7F));
      4:       cp = CodeW'($urandom_range(32'h00, 32'h1F));
      5:       cp = CodeW'($urandom_range(32'h80, 32'hFF));
      6:       cp = CodeW'($urandom_range(32'h100, 32'hFFF));
      default: cp = CodeW'($urandom);
    endcase
    return cp;
  endfunction

  task automatic test_narrow_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_mode(ModeNarrow);
    send_code(16'h0000);
    send_code(16'h000F);
    send_code(16'h0010);
    send_code(16'h001F);
    send_code(16'h0020);
    send_code(16'h0041);
    send_code(16'h007E);
    send_code(16'h007F);
    send_code(16'h0080);
    send_code(CodeNbsp);
    send_code(16'h00FF);
    send_code(16'h0100);
    send_code(16'h0FFF);
    send_code(16'h1000);
    send_code(16'hFFFF);
    send_code(ChAmp);
    send_code(ChLt);
    send_code(ChGt);
    send_code(ChQuot);
    send_code(ChApos);
  endtask

  task automatic test_wide_directed();
    send_idle_pct = 28;
    stall_pct     = 28;
    write_mode(ModeWide);
    send_code(16'h0000);
    send_code(16'h0080);
    send_code(16'hFFFF);
    send_code(CodeNbsp);
    send_code(ChAmp);
    send_code(ChLt);
    send_code(ChGt);
    send_code(ChQuot);
    send_code(ChApos);
  endtask

  // Random words in both modes under one idling pattern
  task automatic test_random_traffic(input int idle_pct, input int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int m = 0; m < 2; m++) begin
      write_mode(m == 0 ? ModeNarrow : ModeWide);
      repeat (WordsPerPhase) send_code(pick_code());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_narrow_directed();
    test_wide_directed();
    test_random_traffic(0, 0);
    test_random_traffic(82, 0);
    test_random_traffic(0, 82);
    test_random_traffic(28, 28);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_symbols.size() != 0) begin
      report_mismatch("symbols never seen", CodeW'(pending_symbols.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[xml_entity_escape_top.f]
hw/rtl/xee_pkg.sv
hw/rtl/xml_entity_escape_top.sv
test/xml_entity_escape_top_test.sv
